// File: src/ppms_pkg.sv
// Shared constants for the ping-pong marquee scroller.
package ppms_pkg;

  // Default pixel coordinate width.
  localparam int unsigned PixelBitsDef = 12;

  // Fixed field widths of the stream items and registers.
  localparam int unsigned AreaW   = 12;
  localparam int unsigned PeriodW = 16;
  localparam int unsigned GlyphW  = 6;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned TextW   = 12;
  localparam int unsigned PosW    = 13;
  localparam int unsigned FirstW  = 12;
  localparam int unsigned CountW  = 13;
  localparam int unsigned DrawXW  = 7;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 48;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegAreaWidth = 2'd0;
  localparam logic [CfgIdxW-1:0] RegStepPeriod = 2'd1;
  localparam logic [CfgIdxW-1:0] RegPause = 2'd2;
  localparam logic [CfgIdxW-1:0] RegGlyphWidth = 2'd3;

  // Register reset values.
  localparam logic [AreaW-1:0]   AreaReset   = 12'd128;
  localparam logic [PeriodW-1:0] PeriodReset = 16'd50;
  localparam logic [PeriodW-1:0] PauseReset  = 16'd1000;
  localparam logic [GlyphW-1:0]  GlyphReset  = 6'd8;

  // Request kinds carried in tuser.
  localparam logic ReqRender = 1'b0;
  localparam logic ReqReset  = 1'b1;

endpackage

// File: src/ping_pong_marquee_scroller.sv
// Top level of the ping-pong marquee scroller with its shared serial divider.
//
//   Channel   Dir  Handshake                   Payload
//   s_axis    in   s_axis_tvalid_i/tready_o    tuser: req_type; tdata: request
//   m_axis    out  m_axis_tvalid_o/tready_i    tdata: one result per request
//   cfg       in   cfg_we_i (no wait)          cfg_idx_i, cfg_wdata_i
//
// A reset request, static text or a render without a redraw goes from ST_EVAL
// straight to ST_DONE. A redraw after a scroll step passes through ST_STEP,
// ST_PREP, ST_DIV1 and ST_DIV2 before ST_DONE, and a forced redraw without a
// step or the opening timer event skips ST_STEP. In ST_DIV1 and ST_DIV2 the
// shared divider retires two quotient bits per cycle and runs twice, once for
// the first visible character and once for the character count. One item is
// in flight at a time; the input is ready again once the result sits in the
// output register, even while that result still waits for the downstream
// side. rst_ni clears the scroll state and loads the register defaults. No
// clearing pass is needed.
module ping_pong_marquee_scroller #(
  parameter int unsigned PIXEL_BITS = ppms_pkg::PixelBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration write port.
  input  logic                         cfg_we_i,
  input  logic [ppms_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [ppms_pkg::CfgW-1:0]    cfg_wdata_i,
  // Request stream.
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // tdata: now_ms[31:0], text_px[43:32], force_req[44], zero pad [47:45]
  input  logic [ppms_pkg::InDataW-1:0] s_axis_tdata_i,
  // tuser: req_type[0]
  input  logic                         s_axis_tuser_i,
  // Result stream.
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // tdata: updated[0], draw[1], position[14:2], first_char[26:15],
  //        char_count[39:27], draw_x[46:40], zero pad [47]
  output logic [ppms_pkg::OutDataW-1:0] m_axis_tdata_o
);

  // Offset is signed and one bit wider than a pixel coordinate. The
  // divider dividend is that width rounded up to an even bit count.
  localparam int unsigned OfsW  = PIXEL_BITS + 1;
  localparam int unsigned SW    = PIXEL_BITS + 2;
  localparam int unsigned DivW  = 2 * ((PIXEL_BITS + 2) / 2);
  localparam int unsigned Iters = DivW / 2;
  localparam int unsigned CntW  = $clog2(Iters + 1);
  localparam int unsigned WideW = 19;
  localparam int unsigned DrawXW_L = ppms_pkg::DrawXW;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_STEP,
    ST_PREP,
    ST_DIV1,
    ST_DIV2,
    ST_DONE
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [ppms_pkg::AreaW-1:0]   area_q, area_d;
  logic [ppms_pkg::PeriodW-1:0] step_q, step_d;
  logic [ppms_pkg::PeriodW-1:0] pause_q, pause_d;
  logic [ppms_pkg::GlyphW-1:0]  glyph_q, glyph_d;

  // Scroll state.
  logic signed [OfsW-1:0]     offset_q, offset_d;
  logic                       ml_q, ml_d;
  logic [ppms_pkg::TimeW-1:0] next_q, next_d;
  logic                       started_q, started_d;

  // Latched request.
  logic                       req_q, req_d;
  logic [ppms_pkg::TimeW-1:0] now_q, now_d;
  logic [PIXEL_BITS-1:0]      tw_q, tw_d;
  logic                       force_q, force_d;

  // Result flags and divider state.
  logic                       upd_q, upd_d;
  logic                       drw_q, drw_d;
  logic                       fields_q, fields_d;
  logic [5:0]                 rem_q, rem_d;
  logic [DivW-1:0]            quo_q, quo_d;
  logic [CntW-1:0]            cnt_q, cnt_d;
  logic [DivW-1:0]            first_q, first_d;
  logic [5:0]                 r1_q, r1_d;
  logic [DivW:0]              count_q, count_d;

  // Output register.
  logic                          oval_q, oval_d;
  logic [ppms_pkg::OutDataW-1:0] odata_q, odata_d;

  // Helpers.
  logic [16:0]                aw_wide, tw_wide;
  logic [PIXEL_BITS-1:0]      aw_p, tw_in;
  logic [ppms_pkg::GlyphW-1:0] cw;
  logic [ppms_pkg::TimeW-1:0] due, now_pause;
  logic                       hit;
  logic signed [SW-1:0]       pos_e, lim_s, pm_s, pp_s;
  logic [OfsW-1:0]            mag;
  logic [6:0]                 ps;
  logic [5:0]                 dr;
  logic [DivW-1:0]            dq;
  logic [WideW-1:0]           pos_w, first_w, count_w;
  logic [DrawXW_L-1:0]        dx;

  assign aw_wide = 17'(area_q);
  assign tw_wide = 17'(s_axis_tdata_i[43:32]);
  assign aw_p    = aw_wide[PIXEL_BITS-1:0];
  assign tw_in   = tw_wide[PIXEL_BITS-1:0];
  assign cw      = (glyph_q == '0) ? ppms_pkg::GlyphW'(1) : glyph_q;

  // Timer compare with 32-bit wraparound, as a plain unsigned compare.
  assign due       = next_q + 32'(step_q);
  assign hit       = now_q > due;
  assign now_pause = now_q + 32'(pause_q);

  // Scroll step arithmetic.
  assign pos_e = SW'(offset_q);
  assign lim_s = signed'(SW'(aw_p)) - signed'(SW'(tw_q));
  assign pm_s  = pos_e - SW'(1);
  assign pp_s  = pos_e + SW'(1);
  assign mag   = offset_q[OfsW-1] ? OfsW'(-offset_q) : '0;

  // Shared divider: two restoring steps per cycle.
  always_comb begin
    dr = rem_q;
    dq = quo_q;
    ps = '0;
    for (int k = 0; k < 2; k++) begin
      ps = {dr, dq[DivW-1]};
      dq = {dq[DivW-2:0], 1'b0};
      if (ps >= {1'b0, cw}) begin
        ps    = ps - {1'b0, cw};
        dq[0] = 1'b1;
      end
      dr = ps[5:0];
    end
  end

  // Result fields; the draw offset is minus the first division's remainder.
  assign pos_w   = WideW'(offset_q);
  assign first_w = WideW'(first_q);
  assign count_w = WideW'(count_q);
  assign dx      = DrawXW_L'(-{1'b0, r1_q});

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = oval_q;
  assign m_axis_tdata_o  = odata_q;

  always_comb begin
    state_d   = state_q;
    area_d    = area_q;
    step_d    = step_q;
    pause_d   = pause_q;
    glyph_d   = glyph_q;
    offset_d  = offset_q;
    ml_d      = ml_q;
    next_d    = next_q;
    started_d = started_q;
    req_d     = req_q;
    now_d     = now_q;
    tw_d      = tw_q;
    force_d   = force_q;
    upd_d     = upd_q;
    drw_d     = drw_q;
    fields_d  = fields_q;
    rem_d     = rem_q;
    quo_d     = quo_q;
    cnt_d     = cnt_q;
    first_d   = first_q;
    r1_d      = r1_q;
    count_d   = count_q;
    oval_d    = oval_q;
    odata_d   = odata_q;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        ppms_pkg::RegAreaWidth:  area_d  = cfg_wdata_i[ppms_pkg::AreaW-1:0];
        ppms_pkg::RegStepPeriod: step_d  = cfg_wdata_i;
        ppms_pkg::RegPause:      pause_d = cfg_wdata_i;
        ppms_pkg::RegGlyphWidth: glyph_d = cfg_wdata_i[ppms_pkg::GlyphW-1:0];
        default: ;
      endcase
    end

    if (oval_q && m_axis_tready_i) begin
      oval_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          req_d   = s_axis_tuser_i;
          now_d   = s_axis_tdata_i[31:0];
          tw_d    = tw_in;
          force_d = s_axis_tdata_i[44];
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        upd_d    = 1'b0;
        drw_d    = 1'b0;
        fields_d = 1'b0;
        if (req_q == ppms_pkg::ReqReset) begin
          offset_d  = '0;
          ml_d      = 1'b1;
          next_d    = now_q;
          started_d = 1'b0;
          state_d   = ST_DONE;
        end else if (tw_q <= aw_p) begin
          // Static text is shown once; the direction flag marks it shown.
          if (ml_q) begin
            ml_d  = 1'b0;
            upd_d = 1'b1;
            drw_d = 1'b1;
          end
          state_d = ST_DONE;
        end else begin
          drw_d    = force_q | hit;
          fields_d = force_q | hit;
          if (hit) begin
            upd_d  = 1'b1;
            next_d = now_q;
            if (!started_q) begin
              started_d = 1'b1;
              next_d    = now_pause;
            end
          end
          if (hit && started_q) begin
            state_d = ST_STEP;
          end else if (force_q || hit) begin
            state_d = ST_PREP;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_STEP: begin
        if (ml_q) begin
          if (pm_s <= lim_s) begin
            offset_d = OfsW'(lim_s);
            next_d   = now_pause;
            ml_d     = 1'b0;
          end else begin
            offset_d = OfsW'(pm_s);
          end
        end else begin
          if (pp_s >= 0) begin
            offset_d = '0;
            next_d   = now_pause;
            ml_d     = 1'b1;
          end else begin
            offset_d = OfsW'(pp_s);
          end
        end
        state_d = ST_PREP;
      end
      ST_PREP: begin
        quo_d   = DivW'(mag);
        rem_d   = '0;
        cnt_d   = CntW'(Iters);
        state_d = ST_DIV1;
      end
      ST_DIV1: begin
        quo_d = dq;
        rem_d = dr;
        cnt_d = cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          first_d = dq;
          r1_d    = dr;
          // Count = first + (area + remainder) / glyph + 1.
          quo_d   = DivW'({1'b0, aw_p} + OfsW'(dr));
          rem_d   = '0;
          cnt_d   = CntW'(Iters);
          state_d = ST_DIV2;
        end
      end
      ST_DIV2: begin
        quo_d = dq;
        rem_d = dr;
        cnt_d = cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          count_d = (DivW + 1)'(first_q) + (DivW + 1)'(dq) + (DivW + 1)'(1);
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!oval_q || m_axis_tready_i) begin
          oval_d  = 1'b1;
          odata_d = '0;
          odata_d[0] = upd_q;
          odata_d[1] = drw_q;
          if (fields_q) begin
            odata_d[14:2]  = pos_w[ppms_pkg::PosW-1:0];
            odata_d[26:15] = first_w[ppms_pkg::FirstW-1:0];
            odata_d[39:27] = count_w[ppms_pkg::CountW-1:0];
            odata_d[46:40] = dx;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      area_q    <= ppms_pkg::AreaReset;
      step_q    <= ppms_pkg::PeriodReset;
      pause_q   <= ppms_pkg::PauseReset;
      glyph_q   <= ppms_pkg::GlyphReset;
      offset_q  <= '0;
      ml_q      <= 1'b1;
      next_q    <= '0;
      started_q <= 1'b0;
      cnt_q     <= '0;
      oval_q    <= 1'b0;
      odata_q   <= '0;
    end else begin
      state_q   <= state_d;
      area_q    <= area_d;
      step_q    <= step_d;
      pause_q   <= pause_d;
      glyph_q   <= glyph_d;
      offset_q  <= offset_d;
      ml_q      <= ml_d;
      next_q    <= next_d;
      started_q <= started_d;
      cnt_q     <= cnt_d;
      oval_q    <= oval_d;
      odata_q   <= odata_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    now_q    <= now_d;
    tw_q     <= tw_d;
    force_q  <= force_d;
    upd_q    <= upd_d;
    drw_q    <= drw_d;
    fields_q <= fields_d;
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    first_q  <= first_d;
    r1_q     <= r1_d;
    count_q  <= count_d;
  end

endmodule

// File: tb/ping_pong_marquee_scroller_test.sv
// Self-checking testbench for the ping-pong marquee scroller: directed and random scroll traffic.
`timescale 1ns / 1ps

module ping_pong_marquee_scroller_test;

  // One result item of the scroller, in the order of the m_axis tdata fields.
  typedef struct packed {
    logic                                updated;
    logic                                draw;
    logic signed [ppms_pkg::PosW-1:0]    position;
    logic [ppms_pkg::FirstW-1:0]         first_char;
    logic [ppms_pkg::CountW-1:0]         char_count;
    logic signed [ppms_pkg::DrawXW-1:0]  draw_x;
  } scroll_frame_t;

  // Clock, reset and the pins of the block. Every input starts at a known value.
  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           cfg_we_i = 1'b0;
  logic [ppms_pkg::CfgIdxW-1:0]   cfg_idx_i = ppms_pkg::RegAreaWidth;
  logic [ppms_pkg::CfgW-1:0]      cfg_wdata_i = '0;
  logic                           s_axis_tvalid_i = 1'b0;
  logic                           s_axis_tready_o;
  // tdata: now_ms[31:0], text_px[43:32], force_req[44], zero pad [47:45]
  logic [ppms_pkg::InDataW-1:0]   s_axis_tdata_i = '0;
  // tuser: req_type[0]
  logic                           s_axis_tuser_i = ppms_pkg::ReqRender;
  logic                           m_axis_tvalid_o;
  logic                           m_axis_tready_i = 1'b0;
  // tdata: updated[0], draw[1], position[14:2], first_char[26:15],
  //        char_count[39:27], draw_x[46:40], zero pad [47]
  logic [ppms_pkg::OutDataW-1:0]  m_axis_tdata_o;

  ping_pong_marquee_scroller u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // A 20 ns clock period.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // The run is cut off here if the block ever hangs. A correct run with the
  // longest gaps on both sides stays far below this bound.
  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

  // The testbench's own copy of the registers and the scroll state. They are
  // changed only by the predictor below and by the register writes.
  logic [ppms_pkg::AreaW-1:0]        cfg_area   = ppms_pkg::AreaReset;
  logic [ppms_pkg::PeriodW-1:0]      cfg_period = ppms_pkg::PeriodReset;
  logic [ppms_pkg::PeriodW-1:0]      cfg_pause  = ppms_pkg::PauseReset;
  logic [ppms_pkg::GlyphW-1:0]       cfg_glyph  = ppms_pkg::GlyphReset;
  logic signed [ppms_pkg::PosW-1:0]  scroll_ofs = '0;
  bit                                going_left = 1'b1;
  logic [ppms_pkg::TimeW-1:0]        deadline   = '0;
  bit                                scrolling  = 1'b0;

  // Results that the block still owes us, oldest first.
  scroll_frame_t frames_due[$];

  int  fail_count = 0;
  // When set, neither side of the stream inserts idle cycles.
  bit  calm = 1'b0;
  int  stall_left = 0;

  // Works out the result of one accepted request and advances the scroll
  // state. A time step is due only once now_ms is strictly past the deadline
  // plus one period; both sums wrap at 32 bits and the compare is unsigned.
  function automatic scroll_frame_t scroll_step(logic req,
                                                logic [ppms_pkg::TimeW-1:0] now,
                                                logic [ppms_pkg::TextW-1:0] tw,
                                                logic frc);
    scroll_frame_t              r;
    logic [ppms_pkg::TimeW-1:0] due;
    bit                         stepped;
    int                         aw;
    int                         w;
    int                         pos;
    int                         cw;
    int                         first;
    int                         count;
    int                         dx;
    r = '0;
    stepped = 1'b0;
    aw = int'(cfg_area);
    w = int'(tw);
    if (req == ppms_pkg::ReqReset) begin
      scroll_ofs = '0;
      going_left = 1'b1;
      deadline = now;
      scrolling = 1'b0;
      return r;
    end
    // Text that fits is shown once; the direction flag remembers whether it was.
    if (w <= aw) begin
      if (going_left) begin
        going_left = 1'b0;
        r.updated = 1'b1;
        r.draw = 1'b1;
      end
      return r;
    end
    due = deadline + cfg_period;
    if (now > due) begin
      deadline = now;
      stepped = 1'b1;
      if (scrolling) begin
        pos = scroll_ofs;
        if (going_left) begin
          pos = pos - 1;
          if (pos <= aw - w) begin
            pos = aw - w;
            deadline = now + cfg_pause;
            going_left = 1'b0;
          end
        end else begin
          pos = pos + 1;
          if (pos >= 0) begin
            pos = 0;
            deadline = now + cfg_pause;
            going_left = 1'b1;
          end
        end
        scroll_ofs = pos[ppms_pkg::PosW-1:0];
      end else begin
        // The first timer event only arms the opening pause.
        scrolling = 1'b1;
        deadline = deadline + cfg_pause;
      end
    end
    r.updated = stepped;
    if (frc || stepped) begin
      cw = (cfg_glyph == '0) ? 1 : int'(cfg_glyph);
      pos = scroll_ofs;
      first = (pos < 0) ? (-pos) / cw : 0;
      count = (aw - pos) / cw + 1;
      dx = pos + first * cw;
      r.draw = 1'b1;
      r.position = pos[ppms_pkg::PosW-1:0];
      r.first_char = first[ppms_pkg::FirstW-1:0];
      r.char_count = count[ppms_pkg::CountW-1:0];
      r.draw_x = dx[ppms_pkg::DrawXW-1:0];
    end
    return r;
  endfunction

  // Length of one idle stretch: mostly a few cycles, now and then a long one.
  function automatic int pick_gap();
    if ($urandom_range(0, 9) < 8) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  // The result side stalls at random, in short and long stretches.
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      stall_left = stall_left - 1;
      m_axis_tready_i <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      stall_left = pick_gap() - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  // Compares one accepted result with the oldest expectation, field by field.
  // Only the first ten failures are printed in full.
  task automatic check_frame(logic [ppms_pkg::OutDataW-1:0] bus);
    scroll_frame_t got;
    scroll_frame_t want;
    bit            bad;
    got.updated    = bus[0];
    got.draw       = bus[1];
    got.position   = bus[14:2];
    got.first_char = bus[26:15];
    got.char_count = bus[39:27];
    got.draw_x     = bus[46:40];
    if (frames_due.size() == 0) begin
      fail_count++;
      if (fail_count <= 10) begin
        $display("unexpected result item %h with nothing outstanding", bus);
      end
      return;
    end
    want = frames_due.pop_front();
    bad = (got.updated !== want.updated) || (got.draw !== want.draw) ||
          (got.position !== want.position) || (got.first_char !== want.first_char) ||
          (got.char_count !== want.char_count) || (got.draw_x !== want.draw_x);
    if (bad) begin
      fail_count++;
      if (fail_count <= 10) begin
        $display("mismatch: expected upd=%0d draw=%0d pos=%0d first=%0d count=%0d dx=%0d",
                 want.updated, want.draw, want.position, want.first_char,
                 want.char_count, want.draw_x);
        $display("          actual   upd=%0d draw=%0d pos=%0d first=%0d count=%0d dx=%0d",
                 got.updated, got.draw, got.position, got.first_char,
                 got.char_count, got.draw_x);
      end
    end
  endtask

  // Outputs are sampled at the rising edge, before the block updates them.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      check_frame(m_axis_tdata_o);
    end
  end

  // Sends one request item. It is entered and left at a falling edge, so a
  // back-to-back item keeps tvalid high without lowering it in between.
  task automatic send_item(logic req, logic [ppms_pkg::TimeW-1:0] now,
                           logic [ppms_pkg::TextW-1:0] tw, logic frc);
    int gap;
    bit done;
    gap = (!calm && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= req;
    s_axis_tdata_i  <= {3'b000, frc, tw, now};
    done = 1'b0;
    while (!done) begin
      @(posedge clk_i);
      if (s_axis_tready_o) begin
        frames_due.push_back(scroll_step(req, now, tw, frc));
        done = 1'b1;
      end
      @(negedge clk_i);
    end
  endtask

  // Lowers tvalid and waits until every result owed has come back. The guard
  // only matters when the block has lost an item.
  task automatic wait_drained();
    int guard;
    guard = 0;
    s_axis_tvalid_i <= 1'b0;
    while (frames_due.size() != 0 && guard < 20000) begin
      @(negedge clk_i);
      guard++;
    end
  endtask

  // Writes one register in the current cycle and updates our copy of it.
  task automatic write_reg(logic [ppms_pkg::CfgIdxW-1:0] idx,
                           logic [ppms_pkg::CfgW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    case (idx)
      ppms_pkg::RegAreaWidth:  cfg_area   = value[ppms_pkg::AreaW-1:0];
      ppms_pkg::RegStepPeriod: cfg_period = value[ppms_pkg::PeriodW-1:0];
      ppms_pkg::RegPause:      cfg_pause  = value[ppms_pkg::PeriodW-1:0];
      ppms_pkg::RegGlyphWidth: cfg_glyph  = value[ppms_pkg::GlyphW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // Registers change only while the block is idle, once every result is back
  // and a short settling time has passed.
  task automatic apply_settings(int aw, int period, int pause, int glyph);
    wait_drained();
    repeat (25) @(negedge clk_i);
    write_reg(ppms_pkg::RegAreaWidth, ppms_pkg::CfgW'(aw));
    write_reg(ppms_pkg::RegStepPeriod, ppms_pkg::CfgW'(period));
    write_reg(ppms_pkg::RegPause, ppms_pkg::CfgW'(pause));
    write_reg(ppms_pkg::RegGlyphWidth, ppms_pkg::CfgW'(glyph));
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Text width for a scroll session. Most texts are only a few pixels wider
  // than the window, so that a session sees both turning points.
  function automatic logic [ppms_pkg::TextW-1:0] pick_text_width();
    int k;
    int w;
    k = $urandom_range(0, 9);
    if (k < 6) begin
      w = int'(cfg_area) + $urandom_range(1, 8);
    end else if (k == 6) begin
      w = int'(cfg_area) + $urandom_range(9, 40);
    end else if (k == 7) begin
      w = $urandom_range(0, int'(cfg_area));
    end else if (k == 8) begin
      w = 4095;
    end else begin
      w = $urandom_range(0, 4095);
    end
    if (w > 4095) begin
      w = 4095;
    end
    return w[ppms_pkg::TextW-1:0];
  endfunction

  // Random traffic under the current settings. Most of it is sessions that
  // start with a scroll reset and then render with time moving forward by
  // about one period, sometimes by a whole pause and sometimes too little for
  // a step. A few items are pure noise with random time and kind. Halfway
  // through, the sender holds off until every result is back.
  task automatic run_scroll_phase(int n_items);
    logic [ppms_pkg::TimeW-1:0] t;
    logic [ppms_pkg::TimeW-1:0] step_ms;
    logic [ppms_pkg::TextW-1:0] tw;
    int                         sent;
    int                         left_in_session;
    int                         k;
    sent = 0;
    left_in_session = 0;
    t = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 5000) : $urandom;
    tw = pick_text_width();
    while (sent < n_items) begin
      if (sent == n_items / 2) begin
        wait_drained();
      end
      if (left_in_session == 0) begin
        left_in_session = $urandom_range(10, 60);
        tw = pick_text_width();
        if ($urandom_range(0, 9) != 0) begin
          send_item(ppms_pkg::ReqReset, t, ppms_pkg::TextW'($urandom_range(0, 4095)),
                    1'($urandom_range(0, 1)));
          sent++;
        end
      end
      k = $urandom_range(0, 99);
      if (k < 3) begin
        send_item(1'($urandom_range(0, 1)), $urandom,
                  ppms_pkg::TextW'($urandom_range(0, 4095)), 1'($urandom_range(0, 1)));
      end else begin
        if (k < 8) begin
          tw = pick_text_width();
        end
        case ($urandom_range(0, 9))
          0:       step_ms = $urandom_range(0, int'(cfg_period));
          1, 2:    step_ms = cfg_pause + cfg_period + 1 + $urandom_range(0, 3);
          default: step_ms = cfg_period + 1 + $urandom_range(0, 2);
        endcase
        t = t + step_ms;
        send_item(ppms_pkg::ReqRender, t, tw, $urandom_range(0, 3) == 0);
      end
      sent++;
      left_in_session--;
    end
  endtask

  // Under reset settings (window 128, period 50, pause 1000, glyph 8): the
  // first static show, a repeated static render, a scroll reset at the top of
  // the time range with the first compare wrapping, a forced redraw without a
  // step, the opening timer event, the first step left, static text reusing
  // the direction flag mid-scroll, and a step back right that lands on zero.
  task automatic test_static_and_reset();
    send_item(ppms_pkg::ReqRender, 32'd0, 12'd0, 1'b1);
    send_item(ppms_pkg::ReqRender, 32'hFFFF_FFFF, 12'd128, 1'b1);
    send_item(ppms_pkg::ReqReset, 32'hFFFF_FFFF, 12'd4095, 1'b1);
    send_item(ppms_pkg::ReqRender, 32'd0, 12'd4095, 1'b0);
    send_item(ppms_pkg::ReqRender, 32'd0, 12'd4095, 1'b1);
    send_item(ppms_pkg::ReqRender, 32'd50, 12'd4095, 1'b0);
    send_item(ppms_pkg::ReqRender, 32'd1100, 12'd4095, 1'b1);
    send_item(ppms_pkg::ReqRender, 32'd1101, 12'd4095, 1'b0);
    send_item(ppms_pkg::ReqRender, 32'd1101, 12'd100, 1'b0);
    send_item(ppms_pkg::ReqRender, 32'd1200, 12'd4095, 1'b0);
  endtask

  // A text two pixels too wide goes through a whole left and right swing with
  // both end pauses. A wider text then keeps the old offset, and a narrower
  // one clamps it back to its own end on the next step.
  task automatic test_ping_pong();
    logic [ppms_pkg::TimeW-1:0] t;
    t = 32'd5000;
    send_item(ppms_pkg::ReqReset, t, 12'd130, 1'b0);
    send_item(ppms_pkg::ReqRender, t + 51, 12'd130, 1'b0);
    send_item(ppms_pkg::ReqRender, t + 1102, 12'd130, 1'b0);
    send_item(ppms_pkg::ReqRender, t + 1153, 12'd130, 1'b0);
    send_item(ppms_pkg::ReqRender, t + 2204, 12'd130, 1'b0);
    send_item(ppms_pkg::ReqRender, t + 2255, 12'd130, 1'b0);
    send_item(ppms_pkg::ReqRender, t + 2300, 12'd130, 1'b1);
    send_item(ppms_pkg::ReqRender, t + 3306, 12'd4095, 1'b0);
    send_item(ppms_pkg::ReqRender, t + 3357, 12'd4095, 1'b1);
    send_item(ppms_pkg::ReqRender, t + 3408, 12'd129, 1'b0);
  endtask

  // The register extremes: a one-pixel window with no period, no pause and
  // one-pixel glyphs; the widest window, where every text is static; a zero
  // glyph width, which counts as one; and the longest period with wide glyphs.
  task automatic test_register_extremes();
    apply_settings(1, 0, 0, 1);
    run_scroll_phase(170);
    apply_settings(4095, 65535, 65535, 63);
    run_scroll_phase(60);
    apply_settings(100, 3, 10, 0);
    run_scroll_phase(170);
    apply_settings(2, 65535, 0, 63);
    run_scroll_phase(120);
  endtask

  // Random settings with short times so that sessions reach the far end and
  // come back. One phase runs without any idle cycles on either side.
  task automatic test_random_settings();
    int p;
    for (p = 0; p < 4; p++) begin
      apply_settings($urandom_range(1, 300), $urandom_range(0, 100),
                     $urandom_range(0, 300), $urandom_range(0, 63));
      calm = (p == 2);
      run_scroll_phase(150);
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_static_and_reset();
    test_ping_pong();
    test_register_extremes();
    test_random_settings();

    // Let the last results drain, then give the block time to show any
    // result that it should not produce.
    wait_drained();
    repeat (40) @(negedge clk_i);
    fail_count += frames_due.size();
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
